// ----- rtl/pbrle_pkg.sv -----
// Shared constants and controller/datapath interface types for the PackBits encoder.
package pbrle_pkg;

  // Longest literal packet, in data bytes
  localparam int LIT_MAX     = 128;
  // Default longest repeat packet
  localparam int MAX_RUN_DEF = 128;
  // Literal store rows: header position plus LIT_MAX bytes, four bytes a row
  localparam int ROWS        = LIT_MAX / 4 + 1;
  localparam int ROW_W       = $clog2(ROWS);
  // Result word: four bytes plus a 3-bit count, padded to whole bytes
  localparam int OUT_TDATA_W = 40;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic step_main;   // apply an accepted byte
    logic step_fin;    // flush at end of stream
    logic rd_start;    // start reading a literal packet at row 0
    logic lit_load;    // load the current literal row into the output register
    logic run_load;    // load the pending repeat packet into the output register
    logic last;        // loaded word is the last one of this input byte
    logic stream_end;  // loaded word is the last one of the stream
  } dp_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic lit_pend;     // literal packet waiting to go out
    logic run_pend;     // repeat packet waiting to go out
    logic fin_has_out;  // a flush now would close a packet
    logic lit_last_row; // current literal row is the packet's last word
    logic out_free;     // output register can take a word this cycle
  } dp_stat_t;

endpackage

// ----- rtl/pbrle_dp.sv -----
// Datapath: run/literal tracking, literal store, packet descriptors and output register.
module pbrle_dp import pbrle_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  input  logic [7:0]             in_byte,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser
);

  localparam logic [7:0] RUN_LIM = 8'(MAX_RUN);
  localparam logic [7:0] LIT_LIM = 8'(LIT_MAX);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_LIT  = 3'b010,
    MODE_REP  = 3'b100
  } mode_t;

  // Encoder state
  logic [7:0] held_byte_r, held_byte_nxt;
  logic       held_valid_r, held_valid_nxt;
  mode_t      mode_r, mode_nxt;
  logic [7:0] lit_cnt_r, lit_cnt_nxt;
  logic [7:0] rep_cnt_r, rep_cnt_nxt;

  // Closed packets waiting to be sent
  logic       lit_pend_r, lit_pend_nxt;
  logic [7:0] lit_len_r, lit_len_nxt;
  logic       run_pend_r, run_pend_nxt;
  logic [7:0] run_hdr_r, run_hdr_nxt;
  logic [7:0] run_val_r, run_val_nxt;

  // Literal read pointer and store
  logic [ROW_W-1:0] ptr_r, ptr_nxt;
  logic [3:0][7:0]  mem [ROWS];
  logic [3:0][7:0]  rd_data_r;
  logic             rd_en;
  logic [ROW_W-1:0] rd_addr;
  logic             wr_en;
  logic [7:0]       wr_pos;

  // Output register
  logic            out_valid_r, out_valid_nxt;
  logic [3:0][7:0] out_bytes_r, out_bytes_nxt;
  logic [2:0]      out_cnt_r, out_cnt_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_send_r, out_send_nxt;

  logic [7:0]      lc, rc, fl;
  logic            last_row;
  logic [2:0]      row_cnt;
  logic [3:0][7:0] lit_word;
  logic            out_free;

  assign lc       = lit_cnt_r + 8'd1;
  assign rc       = rep_cnt_r + 8'd1;
  assign fl       = lit_cnt_r + {7'd0, held_valid_r};
  assign last_row = (ptr_r == lit_len_r[7:2]);
  assign row_cnt  = last_row ? ({1'b0, lit_len_r[1:0]} + 3'd1) : 3'd4;
  assign out_free = !out_valid_r || out_tready;
  assign wr_pos   = lc;

  // Byte classification and packet closing
  always_comb begin
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    mode_nxt       = mode_r;
    lit_cnt_nxt    = lit_cnt_r;
    rep_cnt_nxt    = rep_cnt_r;
    lit_pend_nxt   = lit_pend_r;
    lit_len_nxt    = lit_len_r;
    run_pend_nxt   = run_pend_r;
    run_hdr_nxt    = run_hdr_r;
    run_val_nxt    = run_val_r;
    wr_en          = 1'b0;

    if (cmd.step_main) begin
      unique case (mode_r)
        MODE_REP: begin
          if (in_byte == held_byte_r) begin
            if (rc >= RUN_LIM) begin
              run_pend_nxt   = 1'b1;
              run_hdr_nxt    = 8'd1 - rc;
              run_val_nxt    = held_byte_r;
              mode_nxt       = MODE_IDLE;
              rep_cnt_nxt    = 8'd0;
              held_valid_nxt = 1'b0;
            end else begin
              rep_cnt_nxt = rc;
            end
          end else begin
            run_pend_nxt   = 1'b1;
            run_hdr_nxt    = 8'd1 - rep_cnt_r;
            run_val_nxt    = held_byte_r;
            mode_nxt       = MODE_IDLE;
            rep_cnt_nxt    = 8'd0;
            held_byte_nxt  = in_byte;
            held_valid_nxt = 1'b1;
          end
        end
        default: begin
          if (!held_valid_r) begin
            held_byte_nxt  = in_byte;
            held_valid_nxt = 1'b1;
          end else if (held_byte_r == in_byte) begin
            // equal pair: close any literal, open a run of two
            if (lit_cnt_r != 8'd0) begin
              lit_pend_nxt = 1'b1;
              lit_len_nxt  = lit_cnt_r;
            end
            lit_cnt_nxt = 8'd0;
            mode_nxt    = MODE_REP;
            rep_cnt_nxt = 8'd2;
            if (RUN_LIM <= 8'd2) begin
              run_pend_nxt   = 1'b1;
              run_hdr_nxt    = 8'd1 - 8'd2;
              run_val_nxt    = held_byte_r;
              mode_nxt       = MODE_IDLE;
              rep_cnt_nxt    = 8'd0;
              held_valid_nxt = 1'b0;
            end
          end else begin
            // held byte goes into the literal
            wr_en       = 1'b1;
            lit_cnt_nxt = lc;
            mode_nxt    = MODE_LIT;
            if (lc >= LIT_LIM) begin
              lit_pend_nxt = 1'b1;
              lit_len_nxt  = LIT_LIM;
              lit_cnt_nxt  = 8'd0;
              mode_nxt     = MODE_IDLE;
            end
            held_byte_nxt = in_byte;
          end
        end
      endcase
    end else if (cmd.step_fin) begin
      if (mode_r == MODE_REP) begin
        run_pend_nxt = 1'b1;
        run_hdr_nxt  = 8'd1 - rep_cnt_r;
        run_val_nxt  = held_byte_r;
      end else begin
        wr_en = held_valid_r;
        if (fl != 8'd0) begin
          lit_pend_nxt = 1'b1;
          lit_len_nxt  = fl;
        end
      end
      held_byte_nxt  = 8'd0;
      held_valid_nxt = 1'b0;
      mode_nxt       = MODE_IDLE;
      lit_cnt_nxt    = 8'd0;
      rep_cnt_nxt    = 8'd0;
    end

    if (cmd.lit_load && last_row) begin
      lit_pend_nxt = 1'b0;
    end
    if (cmd.run_load) begin
      run_pend_nxt = 1'b0;
    end
  end

  // Literal row pointer and store read
  always_comb begin
    ptr_nxt = ptr_r;
    rd_en   = 1'b0;
    rd_addr = ptr_r + ROW_W'(1);
    if (cmd.rd_start) begin
      ptr_nxt = '0;
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd.lit_load && !last_row) begin
      ptr_nxt = ptr_r + ROW_W'(1);
      rd_en   = 1'b1;
    end
  end

  // Literal word: header in the first lane of row 0, unused lanes zero
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lit_word[i] = rd_data_r[i];
      if (i == 0 && ptr_r == '0) begin
        lit_word[i] = lit_len_r - 8'd1;
      end
      if (3'(i) >= row_cnt) begin
        lit_word[i] = 8'd0;
      end
    end
  end

  // Output register load
  always_comb begin
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_bytes_nxt = out_bytes_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    out_send_nxt  = out_send_r;
    if (cmd.lit_load) begin
      out_valid_nxt = 1'b1;
      out_bytes_nxt = lit_word;
      out_cnt_nxt   = row_cnt;
      out_last_nxt  = cmd.last;
      out_send_nxt  = cmd.stream_end;
    end else if (cmd.run_load) begin
      out_valid_nxt = 1'b1;
      out_bytes_nxt = {8'd0, 8'd0, run_val_r, run_hdr_r};
      out_cnt_nxt   = 3'd2;
      out_last_nxt  = cmd.last;
      out_send_nxt  = cmd.stream_end;
    end
  end

  // Literal store: byte-lane write, registered row read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_pos[7:2]][wr_pos[1:0]] <= held_byte_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_byte_r  <= 8'd0;
      mode_r       <= MODE_IDLE;
      lit_cnt_r    <= 8'd0;
      rep_cnt_r    <= 8'd0;
      lit_pend_r   <= 1'b0;
      run_pend_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_byte_r  <= held_byte_nxt;
      mode_r       <= mode_nxt;
      lit_cnt_r    <= lit_cnt_nxt;
      rep_cnt_r    <= rep_cnt_nxt;
      lit_pend_r   <= lit_pend_nxt;
      run_pend_r   <= run_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    lit_len_r   <= lit_len_nxt;
    run_hdr_r   <= run_hdr_nxt;
    run_val_r   <= run_val_nxt;
    ptr_r       <= ptr_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
    out_send_r  <= out_send_nxt;
  end

  assign stat.lit_pend     = lit_pend_r;
  assign stat.run_pend     = run_pend_r;
  assign stat.fin_has_out  = (mode_r == MODE_REP) || (lit_cnt_r != 8'd0) || held_valid_r;
  assign stat.lit_last_row = last_row;
  assign stat.out_free     = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cnt_r, out_bytes_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_send_r;

endmodule

// ----- rtl/pbrle_ctrl.sv -----
// Sequencer: accepts bytes, runs the end-of-stream flush and sends closed packets word by word.
module pbrle_ctrl import pbrle_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tlast,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LIT  = 3'b010,
    S_RUN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   fin_todo_r, fin_todo_nxt;
  logic   step_fin_r, step_fin_nxt;
  logic   more_fin;

  // A flush still to come that will add a packet
  assign more_fin = fin_todo_r && stat.fin_has_out;

  always_comb begin
    state_nxt    = state_r;
    fin_todo_nxt = fin_todo_r;
    step_fin_nxt = step_fin_r;
    cmd          = '0;
    in_tready    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (stat.lit_pend) begin
          cmd.rd_start = 1'b1;
          state_nxt    = S_LIT;
        end else if (stat.run_pend) begin
          state_nxt = S_RUN;
        end else if (fin_todo_r) begin
          cmd.step_fin = 1'b1;
          fin_todo_nxt = 1'b0;
        end else begin
          in_tready = 1'b1;
          if (in_tvalid) begin
            cmd.step_main = 1'b1;
            fin_todo_nxt  = in_tlast;
            step_fin_nxt  = in_tlast;
          end
        end
      end
      S_LIT: begin
        if (stat.out_free) begin
          cmd.lit_load   = 1'b1;
          cmd.last       = stat.lit_last_row && !stat.run_pend && !more_fin;
          cmd.stream_end = cmd.last && step_fin_r;
          if (stat.lit_last_row) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RUN: begin
        if (stat.out_free) begin
          cmd.run_load   = 1'b1;
          cmd.last       = !more_fin;
          cmd.stream_end = cmd.last && step_fin_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fin_todo_r <= 1'b0;
      step_fin_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fin_todo_r <= fin_todo_nxt;
      step_fin_r <= step_fin_nxt;
    end
  end

endmodule

// ----- rtl/packbits_rle_encoder.sv -----
// Top level of the PackBits run-length encoder.
//
// Usage: raw bytes enter on the in_ channel, one byte per word, in_tlast set on
// the last byte of a stream. Compressed output leaves on the out_ channel as
// words of up to four bytes; each packet starts a new word. out_tlast marks the
// last word caused by an input byte, out_tuser the last word of the stream.
// Throughput: a byte that closes no packet leaves the encoder ready for the next
// byte. When packets close, each is dispatched in turn and sent word by word (a
// repeat packet is one word, a literal of n bytes ceil((n+1)/4) words, read from
// the literal store one row per cycle while the output register is free); a final
// byte adds a flush step. At most two packets close per input byte.
// A receiver stall holds the output register and the sequencer waits; no input
// is taken until all words of the current byte are loaded.
// Reset clears the encoder state and the output valid; the literal store needs
// no clearing, since only written entries are read.
module packbits_rle_encoder import pbrle_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,   // final_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_byte0, out_byte1, out_byte2,
                                             // out_byte3, byte_count[34:32], zero pad
  output logic                   out_tlast,  // run_end
  output logic                   out_tuser   // stream_end
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pbrle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pbrle_dp #(
    .MAX_RUN (MAX_RUN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_byte    (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- dv/packbits_rle_encoder_tb.sv -----
// Testbench for the PackBits encoder: byte streams in, predicted packet words checked out.
package pbrle_tb_pkg;
  import pbrle_pkg::*;

  localparam int RUN_LIMIT = MAX_RUN_DEF;

  typedef enum logic [1:0] {
    PB_IDLE,
    PB_LIT,
    PB_REP
  } pb_mode_e;

  // One output word: bytes in stream order from data[0], count, end flags
  typedef struct packed {
    logic            stream_end;
    logic            run_end;
    logic [2:0]      cnt;
    logic [3:0][7:0] data;
  } pb_word_t;

  class pb_scoreboard;
    // Encoder state as seen from outside
    logic [7:0] lit_buf [LIT_MAX];
    int         lit_len;
    int         run_len;
    logic [7:0] held;
    bit         held_ok;
    pb_mode_e   mode;

    pb_word_t   step_words[$];
    pb_word_t   expected_words[$];
    int         errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      lit_len = 0;
      run_len = 0;
      held    = '0;
      held_ok = 0;
      mode    = PB_IDLE;
    endfunction

    // Split one packet into words of up to four bytes
    function void split_packet(logic [7:0] pkt[$]);
      pb_word_t w;
      int       n;
      for (int i = 0; i < pkt.size(); i += 4) begin
        w = '0;
        n = pkt.size() - i;
        if (n > 4) n = 4;
        for (int j = 0; j < n; j++) w.data[j] = pkt[i+j];
        w.cnt = 3'(n);
        step_words.push_back(w);
      end
    endfunction

    function void close_literal();
      logic [7:0] pkt[$];
      if (lit_len > 0) begin
        pkt.push_back(8'(lit_len - 1));
        for (int i = 0; i < lit_len; i++) pkt.push_back(lit_buf[i]);
        split_packet(pkt);
      end
      lit_len = 0;
      mode    = PB_IDLE;
    endfunction

    function void close_repeat();
      logic [7:0] pkt[$];
      pkt.push_back(8'(257 - run_len));
      pkt.push_back(held);
      split_packet(pkt);
      run_len = 0;
      held_ok = 0;
      mode    = PB_IDLE;
    endfunction

    function void add_literal(logic [7:0] v);
      lit_buf[lit_len] = v;
      lit_len++;
      mode = PB_LIT;
      if (lit_len >= LIT_MAX) close_literal();
    endfunction

    // Accepted input byte: work out the words it causes
    function void note_byte(logic [7:0] b, logic fin);
      step_words.delete();
      if (mode == PB_REP) begin
        if (b == held) begin
          run_len++;
          if (run_len >= RUN_LIMIT) close_repeat();
        end else begin
          close_repeat();
          held    = b;
          held_ok = 1;
        end
      end else if (!held_ok) begin
        held    = b;
        held_ok = 1;
      end else if (held == b) begin
        close_literal();
        mode    = PB_REP;
        run_len = 2;
        if (run_len >= RUN_LIMIT) close_repeat();
      end else begin
        add_literal(held);
        held = b;
      end

      // End of stream flushes everything pending
      if (fin) begin
        if (mode == PB_REP) begin
          close_repeat();
        end else begin
          if (held_ok) begin
            held_ok = 0;
            add_literal(held);
          end
          close_literal();
        end
        clear_state();
        if (step_words.size() > 0) step_words[step_words.size()-1].stream_end = 1'b1;
      end
      if (step_words.size() > 0) step_words[step_words.size()-1].run_end = 1'b1;
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
    endfunction

    function void report(string field, logic [7:0] exp_v, logic [7:0] act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
    endfunction

    // Accepted output word: compare with the oldest expected word
    function void check_word(logic [OUT_TDATA_W-1:0] tdata, logic tlast, logic tuser);
      pb_word_t exp_w;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none actual %h last=%b user=%b",
                 $time, tdata, tlast, tuser);
        return;
      end
      exp_w = expected_words.pop_front();
      for (int i = 0; i < 4; i++)
        if (tdata[8*i +: 8] !== exp_w.data[i])
          report($sformatf("out_byte%0d", i), exp_w.data[i], tdata[8*i +: 8]);
      if (tdata[34:32] !== exp_w.cnt)
        report("byte_count", 8'(exp_w.cnt), 8'(tdata[34:32]));
      if (tlast !== exp_w.run_end)
        report("run_end", 8'(exp_w.run_end), 8'(tlast));
      if (tuser !== exp_w.stream_end)
        report("stream_end", 8'(exp_w.stream_end), 8'(tuser));
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass
endpackage

module packbits_rle_encoder_tb;
  import pbrle_pkg::*;
  import pbrle_tb_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;

  pb_scoreboard sb = new();
  logic [7:0]   stream_q[$];
  bit           calm = 1'b0;
  int           cycles = 0;
  int           rand_bytes;

  packbits_rle_encoder #(.MAX_RUN(RUN_LIMIT)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none in calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver stalls
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Result word monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_word(out_tdata, out_tlast, out_tuser);
  end

  // One input word; returns at the falling edge after acceptance
  task automatic send_byte(logic [7:0] b, logic fin);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, fin);
    @(negedge clk);
  endtask

  // Send the queued stream with the final flag on its last byte
  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++)
      send_byte(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
  endtask

  // Random stream of runs, clean literals and small-alphabet noise
  task automatic build_random_stream();
    int         nseg;
    int         r;
    int         len;
    logic [7:0] v;
    nseg = $urandom_range(1, 5);
    for (int s = 0; s < nseg; s++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        v   = pick_value();
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(120, 131) : $urandom_range(2, 6);
        repeat (len) stream_q.push_back(v);
      end else if (r < 80) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          do v = pick_value();
          while (stream_q.size() > 0 && v == stream_q[stream_q.size()-1]);
          stream_q.push_back(v);
        end
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) stream_q.push_back(8'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: lone bytes at both extremes
    stream_q = '{8'h00};
    send_stream();
    stream_q = '{8'hFF};
    send_stream();
    // run reaching the end of the stream
    stream_q = '{8'hAA, 8'hAA};
    send_stream();
    // literal, then run after literal, then trailing byte
    stream_q = '{8'h01, 8'h02, 8'h03, 8'h03, 8'h03, 8'h04};
    send_stream();
    // run, then a differing last byte
    stream_q = '{8'h55, 8'h55, 8'h55, 8'h7E};
    send_stream();
    // trailing byte joins the open literal
    stream_q = '{8'h10, 8'h20, 8'h30};
    send_stream();
    stream_q = '{8'h80, 8'h7F, 8'h7F};
    send_stream();

    // Literal full: 130 bytes with no two neighbors equal
    calm = 1'b1;
    for (int k = 0; k < 130; k++) stream_q.push_back(8'(k));
    send_stream();
    calm = 1'b0;
    // Run full, an equal pair starting a new run, then a different last byte
    repeat (130) stream_q.push_back(8'h3C);
    stream_q.push_back(8'h3D);
    send_stream();
    // Run full followed by a lone equal last byte
    repeat (129) stream_q.push_back(8'hC3);
    send_stream();

    // Random streams
    rand_bytes = 0;
    while (rand_bytes < 100) begin
      calm = ($urandom_range(0, 4) == 0);
      build_random_stream();
      rand_bytes += stream_q.size();
      send_stream();
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    // Drain, then allow for stray words
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pbrle_pkg.sv
rtl/pbrle_dp.sv
rtl/pbrle_ctrl.sv
rtl/packbits_rle_encoder.sv
dv/packbits_rle_encoder_tb.sv
